// ----- hw/rtl/tpdc_pkg.sv -----
// Shared types, widths and the control program of the temperature PI drive controller.
// Used by tpdc_seq and temperature_pi_drive_controller; depends on nothing else.
package tpdc_pkg;

    localparam int ADC_BITS     = 12;
    localparam int COMPARE_BITS = 16;

    // Field widths of the item and register layout.
    localparam int TEMP_W   = 16;
    localparam int CODE_W   = 12;
    localparam int COEFF_W  = 17;
    localparam int DRIVE_W  = 19;
    localparam int WORD_W   = 16;
    localparam int ERR_W    = TEMP_W + 1;
    localparam int PROD_W   = COEFF_W + 1 + ERR_W;
    localparam int ACC_W    = PROD_W + 3;
    localparam int GD_W     = WORD_W + DRIVE_W;
    localparam int NUM_W    = GD_W + WORD_W;
    localparam int SUPPLY_W = ADC_BITS + WORD_W;
    localparam int DEN_W    = SUPPLY_W + 8;
    localparam int QUO_W    = WORD_W;
    localparam int CNT_W    = $clog2(QUO_W);
    localparam int DIV_W    = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;
    localparam int CFG_AW   = 4;
    localparam int CFG_DW   = DRIVE_W;
    localparam int PC_W     = 4;

    localparam logic [31:0] CMP_MAX = 32'((64'd1 << COMPARE_BITS) - 64'd1);

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] REG_REF_TEMP     = 4'd0;
    localparam logic [CFG_AW-1:0] REG_COEFF_NOW    = 4'd1;
    localparam logic [CFG_AW-1:0] REG_COEFF_PREV   = 4'd2;
    localparam logic [CFG_AW-1:0] REG_DRIVE_LIMIT  = 4'd3;
    localparam logic [CFG_AW-1:0] REG_VOLTAGE_GAIN = 4'd4;
    localparam logic [CFG_AW-1:0] REG_PWM_PERIOD   = 4'd5;
    localparam logic [CFG_AW-1:0] REG_SUPPLY_LSB   = 4'd6;
    localparam logic [CFG_AW-1:0] REG_MIN_COMPARE  = 4'd7;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_WAIT,
        OP_ERR,
        OP_MUL_NOW,
        OP_MUL_PREV,
        OP_SUB,
        OP_CLAMP,
        OP_MUL_GD,
        OP_MUL_P,
        OP_CHECK,
        OP_DIV,
        OP_FLOOR,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_IF_ZERO,
        C_IF_OVF,
        C_IF_CNT
    } cond_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } ctrl_t;

    // Datapath status seen by the sequencer.
    typedef struct packed {
        logic in_valid;
        logic out_busy;
        logic supply_zero;
        logic div_ovf;
        logic cnt_nz;
    } status_t;

    localparam logic [PC_W-1:0] PC_WAIT = 4'd0;
    localparam logic [PC_W-1:0] PC_DIV  = 4'd9;
    localparam logic [PC_W-1:0] PC_EMIT = 4'd11;

    // Control program, one word per step.
    function automatic ctrl_t rom_word(input logic [PC_W-1:0] pc);
        ctrl_t w;
        begin
            w = '{op: OP_NOP, cond: C_ALWAYS, target: PC_WAIT};
            case (pc)
                4'd0:  w = '{op: OP_WAIT,     cond: C_NEXT,    target: PC_WAIT};
                4'd1:  w = '{op: OP_ERR,      cond: C_NEXT,    target: PC_WAIT};
                4'd2:  w = '{op: OP_MUL_NOW,  cond: C_NEXT,    target: PC_WAIT};
                4'd3:  w = '{op: OP_MUL_PREV, cond: C_NEXT,    target: PC_WAIT};
                4'd4:  w = '{op: OP_SUB,      cond: C_NEXT,    target: PC_WAIT};
                4'd5:  w = '{op: OP_CLAMP,    cond: C_IF_ZERO, target: PC_EMIT};
                4'd6:  w = '{op: OP_MUL_GD,   cond: C_NEXT,    target: PC_WAIT};
                4'd7:  w = '{op: OP_MUL_P,    cond: C_NEXT,    target: PC_WAIT};
                4'd8:  w = '{op: OP_CHECK,    cond: C_IF_OVF,  target: PC_EMIT};
                4'd9:  w = '{op: OP_DIV,      cond: C_IF_CNT,  target: PC_DIV};
                4'd10: w = '{op: OP_FLOOR,    cond: C_NEXT,    target: PC_WAIT};
                4'd11: w = '{op: OP_EMIT,     cond: C_ALWAYS,  target: PC_WAIT};
                default: w = '{op: OP_NOP,    cond: C_ALWAYS,  target: PC_WAIT};
            endcase
            return w;
        end
    endfunction

endpackage

// ----- hw/rtl/tpdc_seq.sv -----
// Step counter and control program lookup of the temperature PI drive controller.
// Depends on tpdc_pkg for the control word, status struct and program table.
module tpdc_seq (
    input  logic               aclk,
    input  logic               aresetn,
    input  tpdc_pkg::status_t  status,
    output tpdc_pkg::ctrl_t    ctrl
);

    logic [tpdc_pkg::PC_W-1:0] pc_reg;
    logic [tpdc_pkg::PC_W-1:0] pc_next;
    logic                      hold;
    logic                      take;

    assign ctrl = tpdc_pkg::rom_word(pc_reg);

    // The wait and emit steps hold until their handshake can complete.
    assign hold = ((ctrl.op == tpdc_pkg::OP_WAIT) && !status.in_valid) ||
                  ((ctrl.op == tpdc_pkg::OP_EMIT) && status.out_busy);

    always_comb begin
        case (ctrl.cond)
            tpdc_pkg::C_NEXT:    take = 1'b0;
            tpdc_pkg::C_ALWAYS:  take = 1'b1;
            tpdc_pkg::C_IF_ZERO: take = status.supply_zero;
            tpdc_pkg::C_IF_OVF:  take = status.div_ovf;
            tpdc_pkg::C_IF_CNT:  take = status.cnt_nz;
            default:             take = 1'b1;
        endcase
        if (hold) begin
            pc_next = pc_reg;
        end else if (take) begin
            pc_next = ctrl.target;
        end else begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= tpdc_pkg::PC_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ----- hw/rtl/temperature_pi_drive_controller.sv -----
// Top level of the temperature PI drive controller: config registers, datapath, output register.
// Depends on tpdc_pkg and tpdc_seq.
//
// Use: each input item on the s_ channel carries one cold-side temperature sample and one
// supply ADC code. The block runs an incremental PI law on the temperature error, clamps
// the drive voltage to zero and the drive limit, and turns it into a PWM compare value
// scaled by gain, period and the measured supply. Each item gives exactly one result on
// the m_ channel. Registers are written on the cfg_ channel, which is always ready; write
// them only while no item is in flight.
// Sequence: a microcoded sequencer walks a twelve-step program. The result is loaded into the
// output register at the emit step, reached straight from the clamp step when the supply is
// zero, from the overflow check when the quotient overflows the period, and otherwise after
// the 16-step restoring divider loop and the floor step. The next item is accepted only after
// the previous result is loaded, so the block works on one item at a time.
// Stall: the result waits in the output register while m_tready is low; a new item is
// still accepted and worked on, and only its final load waits for the register to free.
// Reset: aresetn (synchronous, active low) restores the register defaults, clears the
// previous drive and error, empties the output register and returns to the wait step.
module temperature_pi_drive_controller (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [15:0] cold_temp, [27:16] supply_code, rest zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [18:0] drive_voltage, [34:19] compare_value, rest zero
    output logic [1:0]  m_tuser,    // [0] drive_clamped, [1] supply_zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_addr,
    input  logic [18:0] cfg_data
);

    // Configuration registers.
    logic [15:0] ref_temp_reg;
    logic [16:0] coeff_now_reg;
    logic [16:0] coeff_prev_reg;
    logic [18:0] drive_limit_reg;
    logic [15:0] voltage_gain_reg;
    logic [15:0] pwm_period_reg;
    logic [15:0] supply_lsb_reg;
    logic [15:0] min_compare_reg;

    // Controller state.
    logic [tpdc_pkg::DRIVE_W-1:0]       last_drive_reg;
    logic signed [tpdc_pkg::ERR_W-1:0]  last_error_reg;

    // Datapath registers.
    logic [tpdc_pkg::TEMP_W-1:0]        temp_reg;
    logic [tpdc_pkg::ADC_BITS-1:0]      code_reg;
    logic signed [tpdc_pkg::ERR_W-1:0]  err_reg;
    logic [tpdc_pkg::SUPPLY_W-1:0]      supply_reg;
    logic signed [tpdc_pkg::PROD_W-1:0] prod_reg;
    logic signed [tpdc_pkg::ACC_W-1:0]  acc_reg;
    logic [tpdc_pkg::DRIVE_W-1:0]       drive_reg;
    logic                               clamped_reg;
    logic [tpdc_pkg::GD_W-1:0]          gd_reg;
    logic [tpdc_pkg::NUM_W-1:0]         num_reg;
    logic [tpdc_pkg::DIV_W-1:0]         rem_reg;
    logic [tpdc_pkg::DIV_W-1:0]         dsh_reg;
    logic [tpdc_pkg::QUO_W-1:0]         quo_reg;
    logic [tpdc_pkg::CNT_W-1:0]         cnt_reg;
    logic [15:0]                        cmp_reg;

    // Output register.
    logic        m_tvalid_reg;
    logic [18:0] out_drive_reg;
    logic [15:0] out_cmp_reg;
    logic        out_clamped_reg;
    logic        out_zero_reg;

    tpdc_pkg::ctrl_t   ctrl;
    tpdc_pkg::status_t status;

    logic                                out_busy;
    logic signed [tpdc_pkg::ACC_W-1:0]   prod_ext;
    logic signed [tpdc_pkg::ACC_W-1:0]   acc_base;
    logic signed [tpdc_pkg::ACC_W-8-1:0] u_w;
    logic                                u_over;
    logic [tpdc_pkg::DIV_W-1:0]          num_ext;
    logic [tpdc_pkg::DIV_W-1:0]          den_top;
    logic                                div_ovf;
    logic                                rem_ge;
    logic [15:0]                         cmp_floor;
    logic [15:0]                         cmp_sat;

    tpdc_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    assign out_busy = m_tvalid_reg && !m_tready;

    assign status.in_valid    = s_tvalid;
    assign status.out_busy    = out_busy;
    assign status.supply_zero = (supply_reg == '0);
    assign status.div_ovf     = div_ovf;
    assign status.cnt_nz      = (cnt_reg != '0);

    assign s_tready  = (ctrl.op == tpdc_pkg::OP_WAIT);
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, out_cmp_reg, out_drive_reg};
    assign m_tuser  = {out_zero_reg, out_clamped_reg};

    // PI sum: previous drive in Q24 plus one half LSB, then the two error products.
    assign prod_ext = {{(tpdc_pkg::ACC_W - tpdc_pkg::PROD_W){prod_reg[tpdc_pkg::PROD_W-1]}},
                       prod_reg};
    assign acc_base = $signed({{(tpdc_pkg::ACC_W - tpdc_pkg::DRIVE_W - 8){1'b0}},
                               last_drive_reg, 8'd0}) + $signed(tpdc_pkg::ACC_W'(128));
    assign u_w      = acc_reg[tpdc_pkg::ACC_W-1:8];
    assign u_over   = u_w > $signed({{(tpdc_pkg::ACC_W - 8 - tpdc_pkg::DRIVE_W){1'b0}},
                                     drive_limit_reg});

    // The quotient fits the compare field unless num reaches den * 2^16; then it
    // exceeds any period and the result is the period.
    assign num_ext = tpdc_pkg::DIV_W'(num_reg);
    assign den_top = tpdc_pkg::DIV_W'(supply_reg) << (8 + tpdc_pkg::QUO_W);
    assign div_ovf = (num_ext >= den_top);
    assign rem_ge  = (rem_reg >= dsh_reg);

    assign cmp_floor = (quo_reg < min_compare_reg) ? min_compare_reg : quo_reg;
    assign cmp_sat   = (32'(cmp_reg) > tpdc_pkg::CMP_MAX) ? 16'(tpdc_pkg::CMP_MAX) : cmp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_temp_reg     <= 16'd5120;
            coeff_now_reg    <= 17'd36975;
            coeff_prev_reg   <= 17'd36045;
            drive_limit_reg  <= 19'd327680;
            voltage_gain_reg <= 16'd256;
            pwm_period_reg   <= 16'd10000;
            supply_lsb_reg   <= 16'd211;
            min_compare_reg  <= 16'd121;
        end else if (cfg_valid) begin
            case (cfg_addr)
                tpdc_pkg::REG_REF_TEMP:     ref_temp_reg     <= cfg_data[15:0];
                tpdc_pkg::REG_COEFF_NOW:    coeff_now_reg    <= cfg_data[16:0];
                tpdc_pkg::REG_COEFF_PREV:   coeff_prev_reg   <= cfg_data[16:0];
                tpdc_pkg::REG_DRIVE_LIMIT:  drive_limit_reg  <= cfg_data;
                tpdc_pkg::REG_VOLTAGE_GAIN: voltage_gain_reg <= cfg_data[15:0];
                tpdc_pkg::REG_PWM_PERIOD:   pwm_period_reg   <= cfg_data[15:0];
                tpdc_pkg::REG_SUPPLY_LSB:   supply_lsb_reg   <= cfg_data[15:0];
                tpdc_pkg::REG_MIN_COMPARE:  min_compare_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Control state: controller memory and the output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_drive_reg <= '0;
            last_error_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            // A load in the same cycle as a handshake keeps the output valid.
            if ((ctrl.op == tpdc_pkg::OP_EMIT) && !out_busy) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (ctrl.op)
                tpdc_pkg::OP_CLAMP: begin
                    if (u_over) begin
                        last_drive_reg <= drive_limit_reg;
                    end else if (u_w[tpdc_pkg::ACC_W-8-1]) begin
                        last_drive_reg <= '0;
                    end else begin
                        last_drive_reg <= u_w[tpdc_pkg::DRIVE_W-1:0];
                    end
                    last_error_reg <= err_reg;
                end
                default: ;
            endcase
        end
    end

    // Payload datapath, one operation per program step.
    always_ff @(posedge aclk) begin
        case (ctrl.op)
            tpdc_pkg::OP_WAIT: begin
                if (s_tvalid) begin
                    temp_reg <= s_tdata[15:0];
                    code_reg <= s_tdata[16 +: tpdc_pkg::ADC_BITS];
                end
            end
            tpdc_pkg::OP_ERR: begin
                err_reg    <= $signed({temp_reg[15], temp_reg}) -
                              $signed({ref_temp_reg[15], ref_temp_reg});
                supply_reg <= code_reg * supply_lsb_reg;
            end
            tpdc_pkg::OP_MUL_NOW: begin
                prod_reg <= $signed({1'b0, coeff_now_reg}) * err_reg;
            end
            tpdc_pkg::OP_MUL_PREV: begin
                acc_reg  <= acc_base + prod_ext;
                prod_reg <= $signed({1'b0, coeff_prev_reg}) * last_error_reg;
            end
            tpdc_pkg::OP_SUB: begin
                acc_reg <= acc_reg - prod_ext;
            end
            tpdc_pkg::OP_CLAMP: begin
                if (u_over) begin
                    drive_reg   <= drive_limit_reg;
                    clamped_reg <= 1'b1;
                end else if (u_w[tpdc_pkg::ACC_W-8-1]) begin
                    drive_reg   <= '0;
                    clamped_reg <= 1'b1;
                end else begin
                    drive_reg   <= u_w[tpdc_pkg::DRIVE_W-1:0];
                    clamped_reg <= 1'b0;
                end
                // A zero supply skips the divide and reports the period.
                cmp_reg <= pwm_period_reg;
            end
            tpdc_pkg::OP_MUL_GD: begin
                gd_reg <= voltage_gain_reg * drive_reg;
            end
            tpdc_pkg::OP_MUL_P: begin
                num_reg <= gd_reg * pwm_period_reg;
            end
            tpdc_pkg::OP_CHECK: begin
                rem_reg <= num_ext;
                dsh_reg <= tpdc_pkg::DIV_W'(supply_reg) << (8 + tpdc_pkg::QUO_W - 1);
                quo_reg <= '0;
                cnt_reg <= tpdc_pkg::CNT_W'(tpdc_pkg::QUO_W - 1);
                cmp_reg <= pwm_period_reg;
            end
            tpdc_pkg::OP_DIV: begin
                if (rem_ge) begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                quo_reg <= {quo_reg[tpdc_pkg::QUO_W-2:0], rem_ge};
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - 1'b1;
            end
            tpdc_pkg::OP_FLOOR: begin
                cmp_reg <= (cmp_floor > pwm_period_reg) ? pwm_period_reg : cmp_floor;
            end
            tpdc_pkg::OP_EMIT: begin
                if (!out_busy) begin
                    out_drive_reg   <= drive_reg;
                    out_cmp_reg     <= cmp_sat;
                    out_clamped_reg <= clamped_reg;
                    out_zero_reg    <= (supply_reg == '0);
                end
            end
            default: ;
        endcase
    end

    // An accepted item keeps the input side closed until its result is loaded.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted twice without a result in between");

    // The reported drive never exceeds the configured limit.
    a_drive_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[18:0] <= drive_limit_reg))
        else $error("drive voltage above drive limit");

    // A zero supply result carries the period as compare value.
    a_zero_period: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |->
        ((32'(pwm_period_reg) > tpdc_pkg::CMP_MAX) ||
         (m_tdata[34:19] == pwm_period_reg)))
        else $error("zero supply result without period compare");

    // The divider loop never runs past its last quotient bit.
    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ((ctrl.op == tpdc_pkg::OP_DIV) && (cnt_reg == '0)) |=>
        (ctrl.op == tpdc_pkg::OP_FLOOR))
        else $error("divider loop did not end after its last step");

endmodule

// ----- tb/temperature_pi_drive_controller_tb.sv -----
// Self-checking testbench for temperature_pi_drive_controller.
// Depends on tpdc_pkg and the controller RTL. A bit-exact PI and PWM predictor checks every
// result, under directed corner settings, random regulation runs and output backpressure.
`timescale 1ns / 100ps

module temperature_pi_drive_controller_tb;

    localparam int TEMP_MIN      = -12800;
    localparam int TEMP_MAX      = 32767;
    localparam int CODE_MAX      = 4095;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic [tpdc_pkg::CFG_AW-1:0] REG_UNUSED_FIRST =
        tpdc_pkg::REG_MIN_COMPARE + 4'd1;

    typedef enum {CFG_RESET, CFG_TYPICAL, CFG_RANGE, CFG_EXTREME, CFG_RAW} cfg_style_t;

    typedef struct packed {
        logic [tpdc_pkg::DRIVE_W-1:0] drive;
        logic [tpdc_pkg::WORD_W-1:0]  compare;
        logic                         clamped;
        logic                         zero;
    } drive_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;     // [15:0] cold_temp, [27:16] supply_code, rest zero
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;            // [18:0] drive_voltage, [34:19] compare_value, rest zero
    logic [1:0]  m_tuser;            // [0] drive_clamped, [1] supply_zero
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_addr  = '0;
    logic [18:0] cfg_data  = '0;

    // Predictor copy of the registers and the loop state.
    logic [tpdc_pkg::TEMP_W-1:0]  pi_ref_temp;
    logic [tpdc_pkg::COEFF_W-1:0] pi_coeff_now;
    logic [tpdc_pkg::COEFF_W-1:0] pi_coeff_prev;
    logic [tpdc_pkg::DRIVE_W-1:0] pi_drive_limit;
    logic [tpdc_pkg::WORD_W-1:0]  pi_voltage_gain;
    logic [tpdc_pkg::WORD_W-1:0]  pi_pwm_period;
    logic [tpdc_pkg::WORD_W-1:0]  pi_supply_lsb;
    logic [tpdc_pkg::WORD_W-1:0]  pi_min_compare;
    logic [tpdc_pkg::DRIVE_W-1:0] pi_last_drive;
    longint                       pi_last_error;

    logic [tpdc_pkg::CFG_DW-1:0] next_cfg [8];
    drive_result_t               drive_expect_q [$];

    int          n_errors       = 0;
    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    logic        sink_hold      = 1'b0;
    int unsigned cycle_count    = 0;
    event        hold_go;

    temperature_pi_drive_controller u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("temperature_pi_drive_controller verification failed");
            $finish;
        end
    end

    // One control step: incremental PI update, clamp, then the PWM compare value.
    function automatic drive_result_t pi_update(input logic [tpdc_pkg::TEMP_W-1:0] temp_raw,
                                                input logic [tpdc_pkg::CODE_W-1:0] code);
        longint          err;
        longint          acc;
        longint          u;
        longint unsigned supply;
        longint unsigned num;
        longint unsigned cmp;
        drive_result_t   r;
        err = longint'($signed(temp_raw)) - longint'($signed(pi_ref_temp));
        // The sum is exact in Q24; adding half an LSB and flooring rounds it to Q16.
        acc = (longint'(pi_last_drive) <<< 8) + longint'(pi_coeff_now) * err
            - longint'(pi_coeff_prev) * pi_last_error + 128;
        u = acc >>> 8;
        r.clamped = 1'b0;
        if (u > longint'(pi_drive_limit)) begin
            u = longint'(pi_drive_limit);
            r.clamped = 1'b1;
        end
        if (u < 0) begin
            u = 0;
            r.clamped = 1'b1;
        end
        r.drive = u[tpdc_pkg::DRIVE_W-1:0];
        pi_last_drive = r.drive;
        pi_last_error = err;

        supply = 64'(code[tpdc_pkg::ADC_BITS-1:0]) * 64'(pi_supply_lsb);
        r.zero = (supply == 0);
        if (r.zero) begin
            cmp = 64'(pi_pwm_period);
        end else begin
            num = 64'(pi_voltage_gain) * 64'(r.drive) * 64'(pi_pwm_period);
            cmp = num / (supply << 8);
            // The floor comes first, so a period below the minimum still wins.
            if (cmp < 64'(pi_min_compare)) cmp = 64'(pi_min_compare);
            if (cmp > 64'(pi_pwm_period)) cmp = 64'(pi_pwm_period);
        end
        if (cmp > 64'(tpdc_pkg::CMP_MAX)) cmp = 64'(tpdc_pkg::CMP_MAX);
        r.compare = cmp[tpdc_pkg::WORD_W-1:0];
        return r;
    endfunction

    function automatic int rand_temp();
        return int'($urandom_range(TEMP_MAX - TEMP_MIN)) + TEMP_MIN;
    endfunction

    task automatic write_reg(input logic [tpdc_pkg::CFG_AW-1:0] idx,
                             input logic [tpdc_pkg::CFG_DW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            tpdc_pkg::REG_REF_TEMP:     pi_ref_temp     = val[tpdc_pkg::TEMP_W-1:0];
            tpdc_pkg::REG_COEFF_NOW:    pi_coeff_now    = val[tpdc_pkg::COEFF_W-1:0];
            tpdc_pkg::REG_COEFF_PREV:   pi_coeff_prev   = val[tpdc_pkg::COEFF_W-1:0];
            tpdc_pkg::REG_DRIVE_LIMIT:  pi_drive_limit  = val[tpdc_pkg::DRIVE_W-1:0];
            tpdc_pkg::REG_VOLTAGE_GAIN: pi_voltage_gain = val[tpdc_pkg::WORD_W-1:0];
            tpdc_pkg::REG_PWM_PERIOD:   pi_pwm_period   = val[tpdc_pkg::WORD_W-1:0];
            tpdc_pkg::REG_SUPPLY_LSB:   pi_supply_lsb   = val[tpdc_pkg::WORD_W-1:0];
            tpdc_pkg::REG_MIN_COMPARE:  pi_min_compare  = val[tpdc_pkg::WORD_W-1:0];
            default: ;
        endcase
    endtask

    // Stops offering items and waits until every pending result has been checked.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (drive_expect_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes all of next_cfg while the block is idle, plus one write to an unused index.
    task automatic apply_settings();
        drain();
        write_reg(tpdc_pkg::REG_REF_TEMP,     next_cfg[tpdc_pkg::REG_REF_TEMP]);
        write_reg(tpdc_pkg::REG_COEFF_NOW,    next_cfg[tpdc_pkg::REG_COEFF_NOW]);
        write_reg(tpdc_pkg::REG_COEFF_PREV,   next_cfg[tpdc_pkg::REG_COEFF_PREV]);
        write_reg(tpdc_pkg::REG_DRIVE_LIMIT,  next_cfg[tpdc_pkg::REG_DRIVE_LIMIT]);
        write_reg(tpdc_pkg::REG_VOLTAGE_GAIN, next_cfg[tpdc_pkg::REG_VOLTAGE_GAIN]);
        write_reg(tpdc_pkg::REG_PWM_PERIOD,   next_cfg[tpdc_pkg::REG_PWM_PERIOD]);
        write_reg(tpdc_pkg::REG_SUPPLY_LSB,   next_cfg[tpdc_pkg::REG_SUPPLY_LSB]);
        write_reg(tpdc_pkg::REG_MIN_COMPARE,  next_cfg[tpdc_pkg::REG_MIN_COMPARE]);
        write_reg(REG_UNUSED_FIRST + 4'($urandom_range(7)), 19'($urandom()));
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic pick_settings(input cfg_style_t style);
        int coeff;
        case (style)
            CFG_RESET: begin
                next_cfg[tpdc_pkg::REG_REF_TEMP]     = 19'd5120;
                next_cfg[tpdc_pkg::REG_COEFF_NOW]    = 19'd36975;
                next_cfg[tpdc_pkg::REG_COEFF_PREV]   = 19'd36045;
                next_cfg[tpdc_pkg::REG_DRIVE_LIMIT]  = 19'd327680;
                next_cfg[tpdc_pkg::REG_VOLTAGE_GAIN] = 19'd256;
                next_cfg[tpdc_pkg::REG_PWM_PERIOD]   = 19'd10000;
                next_cfg[tpdc_pkg::REG_SUPPLY_LSB]   = 19'd211;
                next_cfg[tpdc_pkg::REG_MIN_COMPARE]  = 19'd121;
            end
            CFG_TYPICAL: begin
                coeff = int'($urandom_range(60000, 20000));
                next_cfg[tpdc_pkg::REG_REF_TEMP] =
                    {3'b000, 16'(int'($urandom_range(9000)) - 1000)};
                next_cfg[tpdc_pkg::REG_COEFF_NOW]    = 19'(coeff);
                next_cfg[tpdc_pkg::REG_COEFF_PREV]   = 19'(coeff - int'($urandom_range(3000)));
                next_cfg[tpdc_pkg::REG_DRIVE_LIMIT]  = 19'($urandom_range(327680, 100000));
                next_cfg[tpdc_pkg::REG_VOLTAGE_GAIN] = 19'($urandom_range(512, 128));
                next_cfg[tpdc_pkg::REG_PWM_PERIOD]   = 19'($urandom_range(20000, 1000));
                next_cfg[tpdc_pkg::REG_SUPPLY_LSB]   = 19'($urandom_range(300, 150));
                next_cfg[tpdc_pkg::REG_MIN_COMPARE]  = 19'($urandom_range(500));
            end
            CFG_RANGE: begin
                next_cfg[tpdc_pkg::REG_REF_TEMP]     = {3'b000, 16'(rand_temp())};
                next_cfg[tpdc_pkg::REG_COEFF_NOW]    = 19'($urandom_range(131071));
                next_cfg[tpdc_pkg::REG_COEFF_PREV]   = 19'($urandom_range(131071));
                next_cfg[tpdc_pkg::REG_DRIVE_LIMIT]  = 19'($urandom_range(327680));
                next_cfg[tpdc_pkg::REG_VOLTAGE_GAIN] = 19'($urandom_range(65535));
                next_cfg[tpdc_pkg::REG_PWM_PERIOD]   = 19'($urandom_range(65535, 1));
                next_cfg[tpdc_pkg::REG_SUPPLY_LSB]   = 19'($urandom_range(65535, 1));
                next_cfg[tpdc_pkg::REG_MIN_COMPARE]  = 19'($urandom_range(65535));
            end
            CFG_EXTREME: begin
                next_cfg[tpdc_pkg::REG_REF_TEMP] =
                    $urandom_range(1) ? 19'd32767 : {3'b000, 16'(TEMP_MIN)};
                next_cfg[tpdc_pkg::REG_COEFF_NOW]    = $urandom_range(1) ? 19'd131071 : 19'd0;
                next_cfg[tpdc_pkg::REG_COEFF_PREV]   = $urandom_range(1) ? 19'd131071 : 19'd0;
                next_cfg[tpdc_pkg::REG_DRIVE_LIMIT]  = $urandom_range(1) ? 19'd327680 : 19'd0;
                next_cfg[tpdc_pkg::REG_VOLTAGE_GAIN] = $urandom_range(1) ? 19'd65535 : 19'd0;
                next_cfg[tpdc_pkg::REG_PWM_PERIOD]   = $urandom_range(1) ? 19'd65535 : 19'd1;
                next_cfg[tpdc_pkg::REG_SUPPLY_LSB]   = $urandom_range(1) ? 19'd65535 : 19'd1;
                next_cfg[tpdc_pkg::REG_MIN_COMPARE]  = $urandom_range(1) ? 19'd65535 : 19'd0;
            end
            default: begin
                // Full-width garbage, upper bits included; the block keeps only each width.
                next_cfg[tpdc_pkg::REG_REF_TEMP]     = 19'($urandom());
                next_cfg[tpdc_pkg::REG_COEFF_NOW]    = 19'($urandom());
                next_cfg[tpdc_pkg::REG_COEFF_PREV]   = 19'($urandom());
                next_cfg[tpdc_pkg::REG_DRIVE_LIMIT]  = 19'($urandom());
                next_cfg[tpdc_pkg::REG_VOLTAGE_GAIN] = 19'($urandom());
                next_cfg[tpdc_pkg::REG_PWM_PERIOD]   = 19'($urandom());
                next_cfg[tpdc_pkg::REG_SUPPLY_LSB]   = 19'($urandom());
                next_cfg[tpdc_pkg::REG_MIN_COMPARE]  = 19'($urandom());
            end
        endcase
    endtask

    // Offers one sample and records its expected result once the block takes it.
    task automatic send_sample(input int temp, input int code);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, 12'(code), 16'(temp)};
        do @(posedge aclk); while (!s_tready);
        drive_expect_q.push_back(pi_update(16'(temp), 12'(code)));
    endtask

    // A temperature that wanders around the setpoint, with occasional jumps, and a supply
    // that is mostly healthy.
    task automatic regulate(input int n_items);
        int setpoint;
        int temp;
        int code;
        int roll;
        setpoint = int'($signed(pi_ref_temp));
        temp = setpoint;
        repeat (n_items) begin
            roll = int'($urandom_range(99));
            if (roll < 8)
                temp = rand_temp();
            else
                temp = temp + int'($urandom_range(600)) - 300 + (setpoint - temp) / 8;
            if (temp < TEMP_MIN) temp = TEMP_MIN;
            if (temp > TEMP_MAX) temp = TEMP_MAX;
            roll = int'($urandom_range(99));
            if (roll < 3)
                code = 0;
            else if (roll < 15)
                code = int'($urandom_range(CODE_MAX));
            else
                code = int'($urandom_range(CODE_MAX, 1500));
            send_sample(temp, code);
        end
    endtask

    task automatic test_reset_settings();
        pick_settings(CFG_RESET);
        apply_settings();
        send_sample(5120, 3000);
        send_sample(5376, 3000);
        send_sample(5632, 2500);
        send_sample(4864, 3500);
        send_sample(TEMP_MAX, CODE_MAX);
        send_sample(TEMP_MAX, CODE_MAX);
        send_sample(TEMP_MIN, CODE_MAX);
        send_sample(TEMP_MIN, CODE_MAX);
        send_sample(5200, 0);
        send_sample(6000, 1);
    endtask

    task automatic test_extreme_settings();
        next_cfg[tpdc_pkg::REG_REF_TEMP]     = 19'd32767;
        next_cfg[tpdc_pkg::REG_COEFF_NOW]    = 19'd131071;
        next_cfg[tpdc_pkg::REG_COEFF_PREV]   = 19'd131071;
        next_cfg[tpdc_pkg::REG_DRIVE_LIMIT]  = 19'd327680;
        next_cfg[tpdc_pkg::REG_VOLTAGE_GAIN] = 19'd65535;
        next_cfg[tpdc_pkg::REG_PWM_PERIOD]   = 19'd65535;
        next_cfg[tpdc_pkg::REG_SUPPLY_LSB]   = 19'd1;
        next_cfg[tpdc_pkg::REG_MIN_COMPARE]  = 19'd65535;
        apply_settings();
        send_sample(TEMP_MAX, CODE_MAX);
        send_sample(TEMP_MIN, CODE_MAX);
        send_sample(TEMP_MIN, 1);
        send_sample(TEMP_MAX, 0);

        // Zero drive limit and a minimum above the period.
        next_cfg[tpdc_pkg::REG_REF_TEMP]    = {3'b000, 16'(TEMP_MIN)};
        next_cfg[tpdc_pkg::REG_COEFF_PREV]  = 19'd0;
        next_cfg[tpdc_pkg::REG_DRIVE_LIMIT] = 19'd0;
        next_cfg[tpdc_pkg::REG_PWM_PERIOD]  = 19'd1000;
        next_cfg[tpdc_pkg::REG_SUPPLY_LSB]  = 19'd65535;
        apply_settings();
        send_sample(TEMP_MAX, CODE_MAX);
        send_sample(TEMP_MIN, 2048);
        send_sample(0, CODE_MAX);

        // Zero period, then a zero supply step size; both lie outside the usual range.
        next_cfg[tpdc_pkg::REG_REF_TEMP]    = 19'd0;
        next_cfg[tpdc_pkg::REG_COEFF_NOW]   = 19'd36975;
        next_cfg[tpdc_pkg::REG_DRIVE_LIMIT] = 19'd327680;
        next_cfg[tpdc_pkg::REG_PWM_PERIOD]  = 19'd0;
        next_cfg[tpdc_pkg::REG_MIN_COMPARE] = 19'd0;
        apply_settings();
        send_sample(6000, CODE_MAX);
        send_sample(8000, 0);
        next_cfg[tpdc_pkg::REG_VOLTAGE_GAIN] = 19'd0;
        next_cfg[tpdc_pkg::REG_PWM_PERIOD]   = 19'd1;
        next_cfg[tpdc_pkg::REG_SUPPLY_LSB]   = 19'd0;
        apply_settings();
        send_sample(9000, CODE_MAX);
        send_sample(-100, CODE_MAX);
    endtask

    task automatic test_random_regulation();
        int         idle_plan [4][2];
        cfg_style_t style_plan [12];
        idle_plan  = '{'{0, 0}, '{70, 0}, '{0, 70}, '{23, 23}};
        style_plan = '{CFG_TYPICAL, CFG_RANGE, CFG_TYPICAL,
                       CFG_EXTREME, CFG_TYPICAL, CFG_RAW,
                       CFG_TYPICAL, CFG_RANGE, CFG_RESET,
                       CFG_EXTREME, CFG_TYPICAL, CFG_RAW};
        for (int p = 0; p < 4; p++) begin
            src_idle_pct   = idle_plan[p][0];
            sink_stall_pct = idle_plan[p][1];
            for (int k = 0; k < 3; k++) begin
                pick_settings(style_plan[p * 3 + k]);
                apply_settings();
                regulate(75);
            end
        end
    endtask

    // The sink holds off for a long stretch while items keep coming, so the block backs up.
    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 20;
        pick_settings(CFG_TYPICAL);
        apply_settings();
        -> hold_go;
        regulate(30);
        drain();
        sink_stall_pct = 0;
    endtask

    initial begin
        forever begin
            @(hold_go);
            sink_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            sink_hold <= 1'b0;
        end
    end

    always @(posedge aclk) begin : result_check
        drive_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (drive_expect_q.size() == 0) begin
                $error("result item arrived with no sample pending");
                n_errors++;
            end else begin
                want = drive_expect_q.pop_front();
                if (m_tdata[18:0] !== want.drive) begin
                    $error("drive_voltage: expected %0d, got %0d", want.drive, m_tdata[18:0]);
                    n_errors++;
                end
                if (m_tdata[34:19] !== want.compare) begin
                    $error("compare_value: expected %0d, got %0d", want.compare,
                           m_tdata[34:19]);
                    n_errors++;
                end
                if (m_tuser[0] !== want.clamped) begin
                    $error("drive_clamped: expected %0d, got %0d", want.clamped, m_tuser[0]);
                    n_errors++;
                end
                if (m_tuser[1] !== want.zero) begin
                    $error("supply_zero: expected %0d, got %0d", want.zero, m_tuser[1]);
                    n_errors++;
                end
            end
        end
        if (sink_hold)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    initial begin
        pi_ref_temp     = 16'd5120;
        pi_coeff_now    = 17'd36975;
        pi_coeff_prev   = 17'd36045;
        pi_drive_limit  = 19'd327680;
        pi_voltage_gain = 16'd256;
        pi_pwm_period   = 16'd10000;
        pi_supply_lsb   = 16'd211;
        pi_min_compare  = 16'd121;
        pi_last_drive   = '0;
        pi_last_error   = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_settings();
        test_extreme_settings();
        test_random_regulation();
        test_backpressure();
        drain();

        if (n_errors == 0)
            $display("temperature_pi_drive_controller verification clean");
        else
            $display("temperature_pi_drive_controller verification failed");
        $finish;
    end

endmodule
